### design/jsd_pkg.sv
`timescale 1ns / 1ps

package jsd_pkg;

    // input and sum widths
    localparam int PROB_BITS    = 16;
    localparam int IN_W         = PROB_BITS + 1;
    localparam int SUM_W        = IN_W + 1;
    localparam int EXP_W        = 5;

    // log2 table and interpolation
    localparam int LOG_IDX_BITS = 8;
    localparam int LOG_ENTRIES  = 1 << LOG_IDX_BITS;
    localparam int MANT_W       = 20;
    localparam int DIFF_W       = MANT_W + 1;
    localparam int FRAC_W       = SUM_W - 1 - LOG_IDX_BITS;
    localparam int LOG_W        = EXP_W + MANT_W;
    localparam logic [DIFF_W-1:0] LOG_ONE = DIFF_W'(1) << MANT_W;

    // term and accumulator formats
    localparam int D_W          = LOG_W + 1;
    localparam int MUL_A_W      = 32;
    localparam int MUL_B_W      = D_W;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int TSUM_W       = 45;
    localparam int RND_SH       = PROB_BITS - 4;
    localparam int RND_W        = TSUM_W - RND_SH;
    localparam int ACC_W        = 48;
    localparam longint ACC_MAX  = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;

    // output scaling
    localparam int OUT_W        = 16;
    localparam int OUT_SH       = 33;
    localparam int LN2_W        = 24;
    localparam logic [LN2_W-1:0] LN2_Q24 = 24'd11629080;
    localparam longint SAT_LIMIT = 64'sd1 <<< 30;

    // log operand and write-back select codes
    localparam logic [1:0] LSEL_P = 2'd0;
    localparam logic [1:0] LSEL_Q = 2'd1;
    localparam logic [1:0] LSEL_S = 2'd2;

    // multiplier operand select codes
    localparam logic [1:0] MUL_LOG = 2'd0;
    localparam logic [1:0] MUL_TP  = 2'd1;
    localparam logic [1:0] MUL_TQ  = 2'd2;
    localparam logic [1:0] MUL_FIN = 2'd3;

    typedef logic [MANT_W-1:0] log_tab_t [LOG_ENTRIES];

    // controller to datapath commands
    typedef struct packed {
        logic       load_in;
        logic       prep_en;
        logic [1:0] prep_sel;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       wb_en;
        logic [1:0] wb_sel;
        logic       dif_en;
        logic       tsum_load;
        logic       tsum_add;
        logic       rnd_en;
        logic       acc_en;
        logic       out_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic last;
        logic out_busy;
    } sts_t;

    // log2 mantissa of 1 + i/entries by repeated squaring in Q1.30
    function automatic logic [MANT_W-1:0] mant_log2(int unsigned i);
        logic [63:0]       x;
        logic [MANT_W-1:0] r;
        int                k;
        x = (64'd1 << 30) + (64'(i) << (30 - LOG_IDX_BITS));
        r = '0;
        for (k = 0; k < MANT_W; k++) begin
            x = (x * x) >> 30;
            r = {r[MANT_W-2:0], 1'b0};
            if (x >= (64'd2 << 30)) begin
                x = x >> 1;
                r[0] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic log_tab_t build_log_tab();
        log_tab_t t;
        int       i;
        for (i = 0; i < LOG_ENTRIES; i++) begin
            t[i] = mant_log2(i);
        end
        return t;
    endfunction

    localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

### design/jsd_ctrl.sv
`timescale 1ns / 1ps

module jsd_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output jsd_pkg::cmd_t   cmd,
    input  jsd_pkg::sts_t   sts
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LGP  = 4'd1;
    localparam logic [3:0] S_LGQ  = 4'd2;
    localparam logic [3:0] S_LGS  = 4'd3;
    localparam logic [3:0] S_LWQ  = 4'd4;
    localparam logic [3:0] S_LWS  = 4'd5;
    localparam logic [3:0] S_DIF  = 4'd6;
    localparam logic [3:0] S_TP   = 4'd7;
    localparam logic [3:0] S_TQ   = 4'd8;
    localparam logic [3:0] S_TSUM = 4'd9;
    localparam logic [3:0] S_RND  = 4'd10;
    localparam logic [3:0] S_ACC  = 4'd11;
    localparam logic [3:0] S_FMUL = 4'd12;
    localparam logic [3:0] S_FOUT = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    // sequencing of log lookups, products and accumulation
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                cmd.load_in = s_valid;
                if (s_valid) begin
                    state_next = S_LGP;
                end
            end
            S_LGP: begin
                cmd.prep_en  = 1'b1;
                cmd.prep_sel = jsd_pkg::LSEL_P;
                state_next   = S_LGQ;
            end
            S_LGQ: begin
                cmd.prep_en  = 1'b1;
                cmd.prep_sel = jsd_pkg::LSEL_Q;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = jsd_pkg::MUL_LOG;
                state_next   = S_LGS;
            end
            S_LGS: begin
                cmd.prep_en  = 1'b1;
                cmd.prep_sel = jsd_pkg::LSEL_S;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = jsd_pkg::MUL_LOG;
                cmd.wb_en    = 1'b1;
                cmd.wb_sel   = jsd_pkg::LSEL_P;
                state_next   = S_LWQ;
            end
            S_LWQ: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = jsd_pkg::MUL_LOG;
                cmd.wb_en   = 1'b1;
                cmd.wb_sel  = jsd_pkg::LSEL_Q;
                state_next  = S_LWS;
            end
            S_LWS: begin
                cmd.wb_en  = 1'b1;
                cmd.wb_sel = jsd_pkg::LSEL_S;
                state_next = S_DIF;
            end
            S_DIF: begin
                cmd.dif_en = 1'b1;
                state_next = S_TP;
            end
            S_TP: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = jsd_pkg::MUL_TP;
                state_next  = S_TQ;
            end
            S_TQ: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = jsd_pkg::MUL_TQ;
                cmd.tsum_load = 1'b1;
                state_next    = S_TSUM;
            end
            S_TSUM: begin
                cmd.tsum_add = 1'b1;
                state_next   = S_RND;
            end
            S_RND: begin
                cmd.rnd_en = 1'b1;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.acc_en = 1'b1;
                state_next = sts.last ? S_FMUL : S_IDLE;
            end
            S_FMUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = jsd_pkg::MUL_FIN;
                state_next  = S_FOUT;
            end
            S_FOUT: begin
                // hold until the output register is free
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### design/jsd_dp.sv
`timescale 1ns / 1ps

module jsd_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  jsd_pkg::cmd_t                cmd,
    output jsd_pkg::sts_t                sts,
    input  logic [jsd_pkg::IN_W-1:0]     s_p_val,
    input  logic [jsd_pkg::IN_W-1:0]     s_q_val,
    input  logic                         s_last,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [jsd_pkg::OUT_W-1:0]    m_divergence,
    output logic                         m_saturated
);

    localparam int IN_W    = jsd_pkg::IN_W;
    localparam int SUM_W   = jsd_pkg::SUM_W;
    localparam int EXP_W   = jsd_pkg::EXP_W;
    localparam int IDX_W   = jsd_pkg::LOG_IDX_BITS;
    localparam int MANT_W  = jsd_pkg::MANT_W;
    localparam int DIFF_W  = jsd_pkg::DIFF_W;
    localparam int FRAC_W  = jsd_pkg::FRAC_W;
    localparam int LOG_W   = jsd_pkg::LOG_W;
    localparam int D_W     = jsd_pkg::D_W;
    localparam int A_W     = jsd_pkg::MUL_A_W;
    localparam int B_W     = jsd_pkg::MUL_B_W;
    localparam int PROD_W  = jsd_pkg::PROD_W;
    localparam int TSUM_W  = jsd_pkg::TSUM_W;
    localparam int RND_SH  = jsd_pkg::RND_SH;
    localparam int RND_W   = jsd_pkg::RND_W;
    localparam int ACC_W   = jsd_pkg::ACC_W;
    localparam int OUT_W   = jsd_pkg::OUT_W;
    localparam int OUT_SH  = jsd_pkg::OUT_SH;
    localparam int SCL_W   = PROD_W - OUT_SH;

    localparam logic [EXP_W-1:0]        TOP_BIT  = EXP_W'(SUM_W - 1);
    localparam logic [IDX_W-1:0]        IDX_LAST = IDX_W'(jsd_pkg::LOG_ENTRIES - 1);
    localparam logic signed [ACC_W:0]   ACC_HI   = (ACC_W + 1)'(jsd_pkg::ACC_MAX);
    localparam logic signed [ACC_W:0]   ACC_LO   = -ACC_HI;
    localparam logic signed [ACC_W-1:0] ACC_SAT  = ACC_W'(jsd_pkg::SAT_LIMIT);
    localparam logic signed [TSUM_W-1:0] RND_HALF = TSUM_W'(1) << (RND_SH - 1);
    localparam logic [PROD_W-1:0]       OUT_RND  = PROD_W'(1) << (OUT_SH - 1);
    localparam logic [SCL_W-1:0]        OUT_MAXV = SCL_W'((1 << OUT_W) - 1);

    // captured item
    logic [IN_W-1:0]  p_reg;
    logic [IN_W-1:0]  q_reg;
    logic [SUM_W-1:0] s_reg;
    logic             last_reg;

    // log prep stage
    logic [SUM_W-1:0]  x_sel;
    logic [EXP_W-1:0]  lead;
    logic [SUM_W-1:0]  norm;
    logic [IDX_W-1:0]  idx;
    logic [DIFF_W-1:0] t0;
    logic [DIFF_W-1:0] t1;
    logic [LOG_W-1:0]  base_reg;
    logic [DIFF_W-1:0] diff_reg;
    logic [FRAC_W-1:0] frac_reg;

    // multiplier stage
    logic signed [A_W-1:0]    mul_a;
    logic signed [B_W-1:0]    mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic [LOG_W-1:0]         mbase_reg;

    // logs, log differences, terms
    logic [LOG_W-1:0]         lx;
    logic [LOG_W-1:0]         lp_reg;
    logic [LOG_W-1:0]         lq_reg;
    logic [LOG_W-1:0]         ls_reg;
    logic signed [D_W-1:0]    dp_reg;
    logic signed [D_W-1:0]    dq_reg;
    logic signed [TSUM_W-1:0] tsum_reg;
    logic signed [TSUM_W-1:0] rnd_sum;
    logic signed [RND_W-1:0]  rnd_reg;

    // accumulator and output
    logic signed [ACC_W:0]    acc_sum;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [PROD_W-1:0]        scl_sum;
    logic [SCL_W-1:0]         scaled;
    logic [OUT_W-1:0]         div_val;
    logic                     sat_val;
    logic                     m_valid_reg;
    logic [OUT_W-1:0]         m_divergence_reg;
    logic                     m_saturated_reg;

    assign sts.last     = last_reg;
    assign sts.out_busy = m_valid_reg && !m_ready;

    // log operand select and normalization
    always_comb begin
        unique case (cmd.prep_sel)
            jsd_pkg::LSEL_P: x_sel = SUM_W'(p_reg);
            jsd_pkg::LSEL_Q: x_sel = SUM_W'(q_reg);
            default:         x_sel = s_reg;
        endcase
        lead = '0;
        for (int b = 0; b < SUM_W; b++) begin
            if (x_sel[b]) begin
                lead = EXP_W'(b);
            end
        end
        norm = x_sel << (TOP_BIT - lead);
    end

    assign idx = norm[SUM_W-2 -: IDX_W];

    // table pair for interpolation, one past the end reads as 1.0
    always_comb begin
        t0 = DIFF_W'(jsd_pkg::LOG_TAB[idx]);
        if (idx == IDX_LAST) begin
            t1 = jsd_pkg::LOG_ONE;
        end else begin
            t1 = DIFF_W'(jsd_pkg::LOG_TAB[idx + IDX_W'(1)]);
        end
        if (t1 < t0) begin
            t1 = t0;
        end
    end

    // shared multiplier operands
    always_comb begin
        unique case (cmd.mul_sel)
            jsd_pkg::MUL_LOG: begin
                mul_a = $signed(A_W'(frac_reg));
                mul_b = $signed(B_W'(diff_reg));
            end
            jsd_pkg::MUL_TP: begin
                mul_a = $signed(A_W'(p_reg));
                mul_b = dp_reg;
            end
            jsd_pkg::MUL_TQ: begin
                mul_a = $signed(A_W'(q_reg));
                mul_b = dq_reg;
            end
            default: begin
                mul_a = $signed(acc_reg[A_W-1:0]);
                mul_b = $signed(B_W'(jsd_pkg::LN2_Q24));
            end
        endcase
    end

    // interpolated log write-back value
    assign lx = mbase_reg + LOG_W'(prod_reg[FRAC_W + DIFF_W - 1:FRAC_W]);

    // half away from zero rounding of the pair sum
    assign rnd_sum = tsum_reg + (tsum_reg[TSUM_W-1] ? (RND_HALF - TSUM_W'(1)) : RND_HALF);

    // saturating accumulate
    always_comb begin
        acc_sum = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(rnd_reg);
        if (acc_sum > ACC_HI) begin
            acc_next = ACC_HI[ACC_W-1:0];
        end else if (acc_sum < ACC_LO) begin
            acc_next = ACC_LO[ACC_W-1:0];
        end else begin
            acc_next = acc_sum[ACC_W-1:0];
        end
    end

    // halve, scale to nats and clamp
    assign scl_sum = $unsigned(prod_reg) + OUT_RND;
    assign scaled  = scl_sum[PROD_W-1:OUT_SH];

    always_comb begin
        priority if (acc_reg[ACC_W-1] || acc_reg == '0) begin
            div_val = '0;
            sat_val = 1'b0;
        end else if (acc_reg > ACC_SAT) begin
            div_val = '1;
            sat_val = 1'b1;
        end else if (scaled > OUT_MAXV) begin
            div_val = '1;
            sat_val = 1'b1;
        end else begin
            div_val = scaled[OUT_W-1:0];
            sat_val = 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            p_reg    <= s_p_val;
            q_reg    <= s_q_val;
            s_reg    <= SUM_W'(s_p_val) + SUM_W'(s_q_val);
            last_reg <= s_last;
        end
        if (cmd.prep_en) begin
            base_reg <= {lead, t0[MANT_W-1:0]};
            diff_reg <= t1 - t0;
            frac_reg <= norm[FRAC_W-1:0];
        end
        if (cmd.mul_en) begin
            prod_reg  <= mul_a * mul_b;
            mbase_reg <= base_reg;
        end
        if (cmd.wb_en) begin
            unique case (cmd.wb_sel)
                jsd_pkg::LSEL_P: lp_reg <= lx;
                jsd_pkg::LSEL_Q: lq_reg <= lx;
                default:         ls_reg <= lx;
            endcase
        end
        if (cmd.dif_en) begin
            dp_reg <= $signed(D_W'(jsd_pkg::LOG_ONE) + D_W'(lp_reg) - D_W'(ls_reg));
            dq_reg <= $signed(D_W'(jsd_pkg::LOG_ONE) + D_W'(lq_reg) - D_W'(ls_reg));
        end
        if (cmd.tsum_load) begin
            tsum_reg <= prod_reg[TSUM_W-1:0];
        end else if (cmd.tsum_add) begin
            tsum_reg <= tsum_reg + prod_reg[TSUM_W-1:0];
        end
        if (cmd.rnd_en) begin
            rnd_reg <= rnd_sum[TSUM_W-1:RND_SH];
        end
        if (cmd.out_load) begin
            m_divergence_reg <= div_val;
            m_saturated_reg  <= sat_val;
        end
    end

    // accumulator and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                acc_reg <= '0;
            end else if (cmd.acc_en) begin
                acc_reg <= acc_next;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_divergence = m_divergence_reg;
    assign m_saturated  = m_saturated_reg;

    // a result never overwrites one still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a pending word");

    // a loaded result is offered next cycle and the sum restarts
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (m_valid_reg && acc_reg == '0))
        else $error("result not offered or accumulator not cleared");

    // accumulator stays inside its clamp range
    assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_reg <= $signed(ACC_HI[ACC_W-1:0])) && (acc_reg >= $signed(ACC_LO[ACC_W-1:0])))
        else $error("accumulator outside clamp range");

    // no new item is captured while the pipeline is busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in |-> !(cmd.acc_en || cmd.mul_en || cmd.out_load))
        else $error("item captured during processing");

endmodule

### design/jensen_shannon_divergence_core.sv
`timescale 1ns / 1ps
// channel | handshake         | payload
// input   | s_valid / s_ready | s_p_val[16:0], s_q_val[16:0], s_last
// result  | m_valid / m_ready | m_divergence[15:0], m_saturated
//
// an element pair is processed in full before the next can be taken; one shared multiplier
// does the three interpolated log2 lookups, the two weighted terms and, for a pair marked
// last, the final nats scaling in turn.
// aresetn is synchronous and active low; it clears the accumulator and drops a waiting word.
// a pair marked last waits in its final step while an earlier result is not taken;
// otherwise a pending result does not hold up input words.

module jensen_shannon_divergence_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [jsd_pkg::IN_W-1:0]     s_p_val,
    input  logic [jsd_pkg::IN_W-1:0]     s_q_val,
    input  logic                         s_last,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [jsd_pkg::OUT_W-1:0]    m_divergence,
    output logic                         m_saturated
);

    jsd_pkg::cmd_t cmd;
    jsd_pkg::sts_t sts;

    // sequencer
    jsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // log, product and accumulate datapath
    jsd_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_p_val      (s_p_val),
        .s_q_val      (s_q_val),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_divergence (m_divergence),
        .m_saturated  (m_saturated)
    );

endmodule
